// ----- rtl/core/mfr_pkg.sv -----
// ----------------------------------------------------------------------------
// mfr_pkg
// Types, codes and constants shared by the M-Bus frame receiver.
// ----------------------------------------------------------------------------
package mfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 9;
  localparam int unsigned KindW  = 2;
  localparam int unsigned EventW = 3;

  localparam logic [ByteW-1:0] ByteSingle = 8'hE5;
  localparam logic [ByteW-1:0] ByteShort  = 8'h10;
  localparam logic [ByteW-1:0] ByteLong   = 8'h68;

  localparam logic [IndexW-1:0] ShortHdrLast = 9'd2;
  localparam logic [IndexW-1:0] LongHdrLast  = 9'd6;
  localparam logic [IndexW-1:0] LongLenIdx   = 9'd1;
  localparam logic [IndexW-1:0] LongLen2Idx  = 9'd2;
  localparam logic [IndexW-1:0] LongStart2Idx = 9'd3;
  localparam logic [ByteW-1:0]  LongMinLen   = 8'd3;
  localparam logic [IndexW-1:0] LongLenOfs   = 9'd4;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_TAIL   = 2'd3
  } phase_t;

  typedef enum logic [KindW-1:0] {
    KIND_SINGLE = 2'd0,
    KIND_SHORT  = 2'd1,
    KIND_LONG   = 2'd2
  } kind_t;

  typedef enum logic [EventW-1:0] {
    EV_IN_FRAME   = 3'd0,
    EV_OK         = 3'd1,
    EV_BAD_START  = 3'd2,
    EV_BAD_HEADER = 3'd3,
    EV_CHECKSUM   = 3'd4
  } event_t;

  typedef struct packed {
    phase_t            phase;
    kind_t             kind;
    logic [IndexW-1:0] count;
    logic [IndexW-1:0] exp_size;
    logic [ByteW-1:0]  len_field;
    logic [ByteW-1:0]  sum_acc;
    logic              hdr_ok;
  } rx_state_t;

  typedef struct packed {
    logic [ByteW-1:0]  echo_byte;
    logic [IndexW-1:0] byte_index;
    kind_t             frame_kind;
    event_t            event_res;
    logic              frame_end;
  } rx_result_t;

  localparam rx_state_t IdleState = '{
    phase:     PH_IDLE,
    kind:      KIND_SINGLE,
    count:     '0,
    exp_size:  '0,
    len_field: '0,
    sum_acc:   '0,
    hdr_ok:    1'b1
  };

endpackage

// ----- rtl/core/mfr_if.sv -----
// ----------------------------------------------------------------------------
// mfr_in_if / mfr_out_if
// Valid/ready channels for received bytes and per-byte results.
// ----------------------------------------------------------------------------
interface mfr_in_if
  import mfr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfr_out_if
  import mfr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  echo_byte;
  logic [IndexW-1:0] byte_index;
  logic [KindW-1:0]  frame_kind;
  logic [EventW-1:0] event_res;
  logic              frame_end;

  modport source (output valid, output echo_byte, output byte_index, output frame_kind,
                  output event_res, output frame_end, input ready);
  modport sink   (input valid, input echo_byte, input byte_index, input frame_kind,
                  input event_res, input frame_end, output ready);
endinterface

// ----- rtl/core/mfr_parse.sv -----
// ----------------------------------------------------------------------------
// mfr_parse
// Per-byte frame parser step: next receiver state and the byte's result.
// ----------------------------------------------------------------------------
module mfr_parse
  import mfr_pkg::*;
(
  input  rx_state_t        st,
  input  logic [ByteW-1:0] rx_byte,
  output rx_state_t        st_nxt,
  output rx_result_t       res
);

  logic              finish;
  logic [IndexW-1:0] idx;
  logic [ByteW-1:0]  sum_add;
  logic [IndexW:0]   idx_inc;

  assign idx     = st.count;
  assign sum_add = st.sum_acc + rx_byte;
  assign idx_inc = {1'b0, idx} + {{IndexW{1'b0}}, 1'b1};

  // result and finish decision
  always_comb begin
    res.echo_byte  = rx_byte;
    res.byte_index = idx;
    res.frame_kind = st.kind;
    res.event_res  = EV_IN_FRAME;
    finish         = 1'b0;
    unique case (st.phase)
      PH_IDLE: begin
        res.byte_index = '0;
        if (rx_byte == ByteSingle) begin
          res.frame_kind = KIND_SINGLE;
          res.event_res  = EV_OK;
          finish         = 1'b1;
        end else if (rx_byte == ByteShort) begin
          res.frame_kind = KIND_SHORT;
        end else if (rx_byte == ByteLong) begin
          res.frame_kind = KIND_LONG;
        end else begin
          res.frame_kind = KIND_SINGLE;
          res.event_res  = EV_BAD_START;
          finish         = 1'b1;
        end
      end
      PH_HEADER: begin
        if (st.kind != KIND_SHORT && idx >= LongHdrLast &&
            (!st.hdr_ok || st.len_field < LongMinLen)) begin
          res.event_res = EV_BAD_HEADER;
          finish        = 1'b1;
        end
      end
      PH_DATA: begin
        finish = 1'b0;
      end
      PH_TAIL: begin
        if (idx != st.exp_size) begin
          res.event_res = (st.sum_acc == '0) ? EV_OK : EV_CHECKSUM;
          finish        = 1'b1;
        end
      end
      default: finish = 1'b1;
    endcase
    res.frame_end = finish;
  end

  // next state
  always_comb begin
    st_nxt       = st;
    st_nxt.count = idx_inc[IndexW-1:0];
    unique case (st.phase)
      PH_IDLE: begin
        if (rx_byte == ByteShort) begin
          st_nxt.kind  = KIND_SHORT;
          st_nxt.phase = PH_HEADER;
        end else if (rx_byte == ByteLong) begin
          st_nxt.kind  = KIND_LONG;
          st_nxt.phase = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (st.kind == KIND_SHORT) begin
          st_nxt.sum_acc = sum_add;
          if (idx >= ShortHdrLast) begin
            st_nxt.exp_size = ShortHdrLast + 9'd1;
            st_nxt.phase    = PH_TAIL;
          end
        end else begin
          if (idx == LongLenIdx) begin
            st_nxt.len_field = rx_byte;
          end else if (idx == LongLen2Idx) begin
            if (rx_byte != st.len_field) st_nxt.hdr_ok = 1'b0;
          end else if (idx == LongStart2Idx) begin
            if (rx_byte != ByteLong) st_nxt.hdr_ok = 1'b0;
          end else begin
            st_nxt.sum_acc = sum_add;
          end
          if (idx >= LongHdrLast) begin
            st_nxt.exp_size = {1'b0, st.len_field} + LongLenOfs;
            st_nxt.phase    = (st.len_field == LongMinLen) ? PH_TAIL : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        st_nxt.sum_acc = sum_add;
        if (idx_inc >= {1'b0, st.exp_size}) st_nxt.phase = PH_TAIL;
      end
      PH_TAIL: begin
        st_nxt.sum_acc = st.sum_acc - rx_byte;
      end
      default: st_nxt = IdleState;
    endcase
    if (finish) st_nxt = IdleState;
  end

endmodule

// ----- rtl/core/mbus_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// mbus_frame_receiver_core
// M-Bus link-layer frame receiver with per-byte echo and event codes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries received bus bytes, one request per byte.
//   out_ch returns one request per byte: the byte, its index in the frame,
//   the frame kind, an event code and an end-of-frame flag.
//   Recognized frames: single character E5, short frame 10 C A CS SP, and
//   long frame 68 L L 68 C A CI data CS SP with header and checksum checks.
//   Latency: a result is valid the cycle after its byte is accepted.
//   Throughput: one byte per cycle while out_ch is not stalled; the frame state and
//   the result register update in the same cycle as the byte is taken.
//   in_ch.ready is high while the result register is empty or being drained,
//   so a stalled receiver holds the result and stops input after one byte.
//   Reset returns the parser to idle (start search) and empties the result
//   register.
// ----------------------------------------------------------------------------
module mbus_frame_receiver_core
  import mfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mfr_in_if.sink     in_ch,
  mfr_out_if.source  out_ch
);

  rx_state_t  st_r;
  rx_state_t  st_nxt;
  rx_result_t res_r;
  rx_result_t res_nxt;
  logic       out_valid_r;
  logic       in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  mfr_parse u_parse (
    .st      (st_r),
    .rx_byte (in_ch.rx_byte),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= IdleState;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.echo_byte  = res_r.echo_byte;
  assign out_ch.byte_index = res_r.byte_index;
  assign out_ch.frame_kind = res_r.frame_kind;
  assign out_ch.event_res  = res_r.event_res;
  assign out_ch.frame_end  = res_r.frame_end;

endmodule

// ----- rtl/core/mfr_checker.sv -----
// ----------------------------------------------------------------------------
// mfr_checker
// Port-level checks for the M-Bus frame receiver, bound to mbus_frame_receiver_core.
// ----------------------------------------------------------------------------
module mfr_checker
  import mfr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ByteW-1:0]  echo_byte,
  input logic [IndexW-1:0] byte_index,
  input logic [KindW-1:0]  frame_kind,
  input logic [EventW-1:0] event_res,
  input logic              frame_end
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(echo_byte) && $stable(byte_index)
      && $stable(event_res) && $stable(frame_end))
    else $error("stalled result changed");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte produced no result");

  a_end_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (frame_end == (event_res != EV_IN_FRAME)))
    else $error("frame_end disagrees with event code");

  a_bad_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_BAD_START || frame_kind == KIND_SINGLE) |->
      byte_index == '0 && frame_end)
    else $error("start-byte result malformed");

endmodule

bind mbus_frame_receiver_core mfr_checker u_mfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .echo_byte  (out_ch.echo_byte),
  .byte_index (out_ch.byte_index),
  .frame_kind (out_ch.frame_kind),
  .event_res  (out_ch.event_res),
  .frame_end  (out_ch.frame_end)
);
